[rtl/hbf_pkg.sv]
package hbf_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int WINDOW_RADIUS = 13;
  localparam int WIN           = 2 * WINDOW_RADIUS + 1;
  localparam int LINES         = 2 * WINDOW_RADIUS;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int SZ_W          = COL_W + 2;
  localparam int CFG_W         = 11;
  localparam int MIN_SIZE      = 27;
  localparam int MAX_HEIGHT    = 1024;
  localparam int POS_W         = 10;
  localparam int SLOT_W        = $clog2(LINES);
  localparam int PIX_W         = 8;
  localparam int PSUM_W        = $clog2(WIN * 255 + 1);
  localparam int PRE_ST        = $clog2(WIN);
  localparam int COLV_W        = 15;
  localparam int RES_W         = 18;
  localparam int NSCALE        = 4;
  localparam int SCALE_W       = 2;
  localparam int NRANGE        = 6;
  localparam int NSRC          = 3;
  localparam int CHUNK         = 5;
  localparam int NCHUNK        = 4;
  localparam int FIFO_DEPTH    = 16;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int CRED_W        = $clog2(FIFO_DEPTH + 1);

  localparam logic [SCALE_W-1:0] LAST_SCALE = SCALE_W'(NSCALE - 1);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // range slots: centre band, first lobe, middle lobe, last lobe, quad band above/left,
  // quad band below/right. Same numbers serve as rows and as columns.
  localparam int R_V  = 0;
  localparam int R_A  = 1;
  localparam int R_M  = 2;
  localparam int R_B  = 3;
  localparam int R_DN = 4;
  localparam int R_DP = 5;

  // column quantities kept per scale
  localparam int SRC_V = 0;
  localparam int SRC_Y = 1;
  localparam int SRC_D = 2;

  localparam int RLO [NSCALE][NRANGE] = '{
    '{11, 9, 12, 15, 10, 14},
    '{ 9, 6, 11, 16,  7, 14},
    '{ 7, 3, 10, 17,  4, 14},
    '{ 5, 0,  9, 18,  1, 14}
  };
  localparam int RHI [NSCALE][NRANGE] = '{
    '{15, 11, 14, 17, 12, 16},
    '{17, 10, 15, 20, 12, 19},
    '{19,  9, 16, 23, 12, 22},
    '{21,  8, 17, 26, 12, 25}
  };

  // horizontal sum k runs over column range k of this quantity
  function automatic int sum_src(input int k);
    int r;
    begin
      if (k == R_V) r = SRC_Y;
      else if (k == R_DN || k == R_DP) r = SRC_D;
      else r = SRC_V;
      return r;
    end
  endfunction

  function automatic int lo_below(input int s, input int r);
    int v;
    begin
      v = (RLO[s][r] == 0) ? 0 : RLO[s][r] - 1;
      return v;
    end
  endfunction

  typedef logic [WIN-1:0][PIX_W-1:0] column_t;

  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } meta_t;

  typedef struct packed {
    logic [POS_W-1:0]                  row;
    logic [POS_W-1:0]                  col;
    logic [NSCALE-1:0][RES_W-1:0]      dxx;
    logic [NSCALE-1:0][RES_W-1:0]      dyy;
    logic [NSCALE-1:0][RES_W-1:0]      dxy;
  } entry_t;

  typedef struct packed {
    logic pop;
    logic drop;
  } credit_t;

endpackage

[rtl/hbf_front.sv]
module hbf_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [hbf_pkg::PIX_W-1:0] pixel,
  input  logic                     frame_start,
  input  logic                     pix_valid,
  output logic                     pix_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [hbf_pkg::CFG_W-1:0] cfg_data,
  input  hbf_pkg::credit_t         rel,
  output logic                     col_valid,
  output hbf_pkg::column_t         col_out,
  output hbf_pkg::meta_t           meta_out
);

  logic [hbf_pkg::CFG_W-1:0]  w_reg, h_reg;
  logic [hbf_pkg::SZ_W-1:0]   wc, hc, w_ext, h_ext;
  logic [hbf_pkg::COL_W-1:0]  col_cnt, col_base, col_cnt_next;
  logic [hbf_pkg::POS_W-1:0]  row_cnt, row_base, row_cnt_next;
  logic [hbf_pkg::SLOT_W-1:0] slot_cnt, slot_base, slot_cnt_next;
  logic [hbf_pkg::SZ_W-1:0]   col_inc, row_inc;
  logic                       col_wrap, row_wrap, acc;
  logic [hbf_pkg::CRED_W-1:0] cred, cred_next;

  logic [hbf_pkg::LINES*hbf_pkg::PIX_W-1:0] line_mem [hbf_pkg::MAX_WIDTH];
  logic [hbf_pkg::LINES*hbf_pkg::PIX_W-1:0] rd_word;

  logic                       v0;
  logic [hbf_pkg::PIX_W-1:0]  px0;
  logic [hbf_pkg::SLOT_W-1:0] slot0;
  hbf_pkg::meta_t             meta0;
  hbf_pkg::column_t           col_n;

  assign cfg_ready = 1'b1;
  assign pix_ready = (cred < hbf_pkg::CRED_W'(hbf_pkg::FIFO_DEPTH));
  assign acc       = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg <= hbf_pkg::CFG_W'(640);
      h_reg <= hbf_pkg::CFG_W'(480);
    end else if (cfg_valid) begin
      unique case (hbf_pkg::cfg_reg_t'(cfg_index))
        hbf_pkg::REG_WIDTH:  w_reg <= cfg_data;
        hbf_pkg::REG_HEIGHT: h_reg <= cfg_data;
      endcase
    end
  end

  always_comb begin
    w_ext = hbf_pkg::SZ_W'(w_reg);
    h_ext = hbf_pkg::SZ_W'(h_reg);
    if (w_ext < hbf_pkg::SZ_W'(hbf_pkg::MIN_SIZE)) wc = hbf_pkg::SZ_W'(hbf_pkg::MIN_SIZE);
    else if (w_ext > hbf_pkg::SZ_W'(hbf_pkg::MAX_WIDTH)) wc = hbf_pkg::SZ_W'(hbf_pkg::MAX_WIDTH);
    else wc = w_ext;
    if (h_ext < hbf_pkg::SZ_W'(hbf_pkg::MIN_SIZE)) hc = hbf_pkg::SZ_W'(hbf_pkg::MIN_SIZE);
    else if (h_ext > hbf_pkg::SZ_W'(hbf_pkg::MAX_HEIGHT)) hc = hbf_pkg::SZ_W'(hbf_pkg::MAX_HEIGHT);
    else hc = h_ext;

    col_base  = frame_start ? '0 : col_cnt;
    row_base  = frame_start ? '0 : row_cnt;
    slot_base = frame_start ? '0 : slot_cnt;

    col_inc  = hbf_pkg::SZ_W'(col_base) + hbf_pkg::SZ_W'(1);
    row_inc  = hbf_pkg::SZ_W'(row_base) + hbf_pkg::SZ_W'(1);
    col_wrap = (col_inc >= wc);
    row_wrap = (row_inc >= hc);

    col_cnt_next  = col_wrap ? '0 : col_inc[hbf_pkg::COL_W-1:0];
    row_cnt_next  = row_base;
    slot_cnt_next = slot_base;
    if (col_wrap) begin
      if (row_wrap) begin
        row_cnt_next  = '0;
        slot_cnt_next = '0;
      end else begin
        row_cnt_next  = row_inc[hbf_pkg::POS_W-1:0];
        slot_cnt_next = (slot_base == hbf_pkg::SLOT_W'(hbf_pkg::LINES - 1)) ? '0 :
                        slot_base + hbf_pkg::SLOT_W'(1);
      end
    end
  end

  assign cred_next = cred + hbf_pkg::CRED_W'(acc) - hbf_pkg::CRED_W'(rel.pop)
                   - hbf_pkg::CRED_W'(rel.drop);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      slot_cnt <= '0;
      cred     <= '0;
      v0       <= 1'b0;
      col_valid <= 1'b0;
    end else begin
      if (acc) begin
        col_cnt  <= col_cnt_next;
        row_cnt  <= row_cnt_next;
        slot_cnt <= slot_cnt_next;
      end
      cred      <= cred_next;
      v0        <= acc;
      col_valid <= v0;
    end
  end

  // line store: one word per column, one byte per stored line; read-before-write
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_word <= line_mem[col_base];
      line_mem[col_base][{slot_base, 3'b000} +: hbf_pkg::PIX_W] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px0        <= pixel;
      slot0      <= slot_base;
      meta0.emit <= (row_base >= hbf_pkg::POS_W'(hbf_pkg::LINES)) &&
                    (col_base >= hbf_pkg::COL_W'(hbf_pkg::LINES));
      meta0.row  <= row_base - hbf_pkg::POS_W'(hbf_pkg::WINDOW_RADIUS);
      meta0.col  <= hbf_pkg::POS_W'(col_base - hbf_pkg::COL_W'(hbf_pkg::WINDOW_RADIUS));
    end
  end

  // window row y takes stored line (row + y) mod LINES
  always_comb begin
    logic [hbf_pkg::SLOT_W:0] idx;
    idx = '0;
    for (int y = 0; y < hbf_pkg::LINES; y++) begin
      idx = (hbf_pkg::SLOT_W + 1)'(slot0) + (hbf_pkg::SLOT_W + 1)'(y);
      if (idx >= (hbf_pkg::SLOT_W + 1)'(hbf_pkg::LINES))
        idx = idx - (hbf_pkg::SLOT_W + 1)'(hbf_pkg::LINES);
      col_n[y] = rd_word[{idx[hbf_pkg::SLOT_W-1:0], 3'b000} +: hbf_pkg::PIX_W];
    end
    col_n[hbf_pkg::WIN-1] = px0;
  end

  always_ff @(posedge clk) begin
    if (v0) begin
      col_out  <= col_n;
      meta_out <= meta0;
    end
  end

  a_cred_bound: assert property (@(posedge clk) disable iff (rst)
    cred <= hbf_pkg::CRED_W'(hbf_pkg::FIFO_DEPTH))
    else $error("credit count above queue depth");

endmodule

[rtl/hbf_sums.sv]
module hbf_sums (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  hbf_pkg::column_t  col_in,
  input  hbf_pkg::meta_t    meta_in,
  output logic              push,
  output logic              drop,
  output hbf_pkg::entry_t   entry
);

  localparam int NST = hbf_pkg::PRE_ST + 5;
  localparam int ST_CV = hbf_pkg::PRE_ST + 1;
  localparam int ST_T  = NST - 1;

  logic [NST-1:0]  vld;
  hbf_pkg::meta_t  meta [NST];

  logic [hbf_pkg::PSUM_W-1:0] pre_src [hbf_pkg::PRE_ST][hbf_pkg::WIN];
  logic [hbf_pkg::PSUM_W-1:0] pre     [hbf_pkg::PRE_ST][hbf_pkg::WIN];
  logic [hbf_pkg::PSUM_W-1:0] rs      [hbf_pkg::NSCALE][hbf_pkg::NRANGE];
  logic signed [hbf_pkg::COLV_W-1:0] cv   [hbf_pkg::NSCALE][hbf_pkg::NSRC];
  logic signed [hbf_pkg::COLV_W-1:0] hist [hbf_pkg::NSCALE][hbf_pkg::NSRC][hbf_pkg::WIN];
  logic signed [hbf_pkg::RES_W-1:0] part_n [hbf_pkg::NSCALE][hbf_pkg::NRANGE][hbf_pkg::NCHUNK];
  logic signed [hbf_pkg::RES_W-1:0] part   [hbf_pkg::NSCALE][hbf_pkg::NRANGE][hbf_pkg::NCHUNK];
  logic signed [hbf_pkg::RES_W-1:0] tot    [hbf_pkg::NSCALE][hbf_pkg::NRANGE];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[NST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    meta[0] <= meta_in;
    for (int k = 1; k < NST; k++) meta[k] <= meta[k-1];
  end

  // vertical prefix sums of the entering column, one doubling step per stage
  always_comb begin
    for (int i = 0; i < hbf_pkg::WIN; i++) pre_src[0][i] = hbf_pkg::PSUM_W'(col_in[i]);
    for (int k = 1; k < hbf_pkg::PRE_ST; k++)
      for (int i = 0; i < hbf_pkg::WIN; i++) pre_src[k][i] = pre[k-1][i];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < hbf_pkg::PRE_ST; k++)
      for (int i = 0; i < hbf_pkg::WIN; i++)
        pre[k][i] <= (i >= (1 << k)) ?
                     pre_src[k][i] + pre_src[k][(i >= (1 << k)) ? i - (1 << k) : 0] :
                     pre_src[k][i];
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < hbf_pkg::NSCALE; s++)
      for (int r = 0; r < hbf_pkg::NRANGE; r++)
        rs[s][r] <= pre[hbf_pkg::PRE_ST-1][hbf_pkg::RHI[s][r]] -
                    ((hbf_pkg::RLO[s][r] == 0) ? '0 :
                     pre[hbf_pkg::PRE_ST-1][hbf_pkg::lo_below(s, r)]);
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < hbf_pkg::NSCALE; s++) begin
      cv[s][hbf_pkg::SRC_V] <= $signed({2'b00, rs[s][hbf_pkg::R_V]});
      cv[s][hbf_pkg::SRC_Y] <= $signed({2'b00, rs[s][hbf_pkg::R_A]})
                             - ($signed({2'b00, rs[s][hbf_pkg::R_M]}) <<< 1)
                             + $signed({2'b00, rs[s][hbf_pkg::R_B]});
      cv[s][hbf_pkg::SRC_D] <= $signed({2'b00, rs[s][hbf_pkg::R_DN]})
                             - $signed({2'b00, rs[s][hbf_pkg::R_DP]});
    end
  end

  // column history mirrors the window: one shift per pixel
  always_ff @(posedge clk) begin
    if (vld[ST_CV]) begin
      for (int s = 0; s < hbf_pkg::NSCALE; s++)
        for (int q = 0; q < hbf_pkg::NSRC; q++)
          for (int x = 0; x < hbf_pkg::WIN; x++)
            hist[s][q][x] <= (x == hbf_pkg::WIN - 1) ? cv[s][q] :
                             hist[s][q][(x < hbf_pkg::WIN - 1) ? x + 1 : x];
    end
  end

  always_comb begin
    int x;
    int xi;
    x  = 0;
    xi = 0;
    for (int s = 0; s < hbf_pkg::NSCALE; s++)
      for (int k = 0; k < hbf_pkg::NRANGE; k++)
        for (int j = 0; j < hbf_pkg::NCHUNK; j++) begin
          part_n[s][k][j] = '0;
          for (int e = 0; e < hbf_pkg::CHUNK; e++) begin
            x  = hbf_pkg::RLO[s][k] + hbf_pkg::CHUNK * j + e;
            xi = (x > hbf_pkg::WIN - 1) ? hbf_pkg::WIN - 1 : x;
            if (x <= hbf_pkg::RHI[s][k])
              part_n[s][k][j] = part_n[s][k][j] +
                                hbf_pkg::RES_W'(hist[s][hbf_pkg::sum_src(k)][xi]);
          end
        end
  end

  always_ff @(posedge clk) begin
    part <= part_n;
    for (int s = 0; s < hbf_pkg::NSCALE; s++)
      for (int k = 0; k < hbf_pkg::NRANGE; k++)
        tot[s][k] <= part[s][k][0] + part[s][k][1] + part[s][k][2] + part[s][k][3];
  end

  always_comb begin
    entry.row = meta[ST_T].row;
    entry.col = meta[ST_T].col;
    for (int s = 0; s < hbf_pkg::NSCALE; s++) begin
      entry.dxx[s] = tot[s][hbf_pkg::R_A] - (tot[s][hbf_pkg::R_M] <<< 1) + tot[s][hbf_pkg::R_B];
      entry.dyy[s] = tot[s][hbf_pkg::R_V];
      entry.dxy[s] = tot[s][hbf_pkg::R_DN] - tot[s][hbf_pkg::R_DP];
    end
  end

  assign push = vld[ST_T] && meta[ST_T].emit;
  assign drop = vld[ST_T] && !meta[ST_T].emit;

endmodule

[rtl/hbf_fifo.sv]
module hbf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hbf_pkg::entry_t din,
  input  logic            pop,
  output hbf_pkg::entry_t dout,
  output logic            empty
);

  hbf_pkg::entry_t               slots [hbf_pkg::FIFO_DEPTH];
  logic [hbf_pkg::FIFO_AW-1:0]   wp, rp;
  logic [hbf_pkg::CRED_W-1:0]    count;
  logic                          full;

  assign empty = (count == '0);
  assign full  = (count == hbf_pkg::CRED_W'(hbf_pkg::FIFO_DEPTH));
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + hbf_pkg::FIFO_AW'(1);
      if (pop)  rp <= rp + hbf_pkg::FIFO_AW'(1);
      count <= count + hbf_pkg::CRED_W'(push) - hbf_pkg::CRED_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue pop while empty");

endmodule

[rtl/hbf_back.sv]
module hbf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  hbf_pkg::entry_t              head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [hbf_pkg::SCALE_W-1:0]  scale,
  output logic [hbf_pkg::POS_W-1:0]    center_row,
  output logic [hbf_pkg::POS_W-1:0]    center_col,
  output logic signed [hbf_pkg::RES_W-1:0] dxx,
  output logic signed [hbf_pkg::RES_W-1:0] dyy,
  output logic signed [hbf_pkg::RES_W-1:0] dxy,
  output logic                         last
);

  hbf_pkg::entry_t               cur;
  logic [hbf_pkg::SCALE_W-1:0]   sc;
  logic                          busy, beat;

  assign beat = busy && res_ready;
  assign pop  = (!busy || (beat && sc == hbf_pkg::LAST_SCALE)) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sc   <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      sc   <= '0;
    end else if (beat) begin
      if (sc == hbf_pkg::LAST_SCALE) busy <= 1'b0;
      else sc <= sc + hbf_pkg::SCALE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  assign res_valid  = busy;
  assign scale      = sc;
  assign center_row = cur.row;
  assign center_col = cur.col;
  assign dxx        = cur.dxx[sc];
  assign dyy        = cur.dyy[sc];
  assign dxy        = cur.dxy[sc];
  assign last       = (sc == hbf_pkg::LAST_SCALE);

  a_mid_centre_holds: assert property (@(posedge clk) disable iff (rst)
    (beat && sc != hbf_pkg::LAST_SCALE) |=> (res_valid && sc == $past(sc) + hbf_pkg::SCALE_W'(1)))
    else $error("centre cut short before its last scale");

endmodule

[rtl/hessian_box_filter_responses.sv]
// A pixel that completes a centre shows its first result after the column stage, the sums pipeline and the queue.
// Throughput: four result beats per centre, so when every pixel yields a centre the result port sets the
//   input pace; pixels without a centre go in at one per cycle while queue credit lasts.
// The input takes a new pixel while earlier ones are in the arithmetic pipeline; a 16-entry
//   queue decouples it from the result port, which emits one scale per cycle while res_ready is high.
// Reset: position counters to zero, size registers to 640 x 480; line store is not cleared.
module hessian_box_filter_responses (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [hbf_pkg::PIX_W-1:0]        pixel,
  input  logic                             frame_start,
  input  logic                             pix_valid,
  output logic                             pix_ready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [hbf_pkg::CFG_W-1:0]        cfg_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [hbf_pkg::SCALE_W-1:0]      scale,
  output logic [hbf_pkg::POS_W-1:0]        center_row,
  output logic [hbf_pkg::POS_W-1:0]        center_col,
  output logic signed [hbf_pkg::RES_W-1:0] dxx,
  output logic signed [hbf_pkg::RES_W-1:0] dyy,
  output logic signed [hbf_pkg::RES_W-1:0] dxy,
  output logic                             last
);

  hbf_pkg::credit_t rel;
  logic             col_valid, push, drop, pop, empty;
  hbf_pkg::column_t col_vec;
  hbf_pkg::meta_t   meta;
  hbf_pkg::entry_t  entry, head;

  assign rel.pop  = pop;
  assign rel.drop = drop;

  hbf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .frame_start (frame_start),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rel         (rel),
    .col_valid   (col_valid),
    .col_out     (col_vec),
    .meta_out    (meta)
  );

  hbf_sums u_sums (
    .clk      (clk),
    .rst      (rst),
    .in_valid (col_valid),
    .col_in   (col_vec),
    .meta_in  (meta),
    .push     (push),
    .drop     (drop),
    .entry    (entry)
  );

  hbf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  hbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .scale      (scale),
    .center_row (center_row),
    .center_col (center_col),
    .dxx        (dxx),
    .dyy        (dyy),
    .dxy        (dxy),
    .last       (last)
  );

endmodule
